FILE: sv/lsf_pkg.sv
// shared types, constants and helpers of the line substring filter
package lsf_pkg;

	// default sizes
	localparam int MAX_PATTERN_DEFAULT = 16;
	localparam int LINE_BUFFER_DEFAULT = 1024;

	// pattern characters held by the two pattern registers
	localparam int PAT_STORE = 16;

	// field widths
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int PLEN_W    = 5;
	localparam int COUNT_W   = 32;

	// character codes
	localparam logic [7:0] NEWLINE     = 8'd10;
	localparam logic [7:0] NUL_BYTE    = 8'd0;
	localparam logic [7:0] UPPER_A     = 8'd65;
	localparam logic [7:0] UPPER_Z     = 8'd90;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// request and result codes
	localparam logic REQ_BYTE     = 1'b0;
	localparam logic REQ_END      = 1'b1;
	localparam logic KIND_REPORT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_IGNORE_CASE  = 3'd3,
		REG_COUNT_ONLY   = 3'd4
	} cfg_reg_e;

	// input beat
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} item_t;

	// result beat
	typedef struct packed {
		logic               result_kind;
		logic [COUNT_W-1:0] line_number;
		logic [COUNT_W-1:0] match_count;
		logic               any_match;
		logic               last;
	} result_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [2*CFG_W-1:0] pattern;
		logic [PLEN_W-1:0]  pattern_length;
		logic               ignore_case;
		logic               count_only;
	} cfg_t;

	// results produced by one item, first goes out first
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} eng_res_t;

	// fold A-Z to a-z when case is ignored
	function automatic logic [7:0] fold_case(input logic [7:0] c, input logic ic);
		if (ic && c >= UPPER_A && c <= UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

	// counter step that stops at all ones
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

endpackage

FILE: sv/lsf_cfg_regs.sv
// configuration register bank of the line substring filter
module lsf_cfg_regs
	import lsf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	logic [CFG_W-1:0]  pat_low_q;
	logic [CFG_W-1:0]  pat_high_q;
	logic [PLEN_W-1:0] plen_q;
	logic              ignore_case_q;
	logic              count_only_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q     <= '0;
			pat_high_q    <= '0;
			plen_q        <= '0;
			ignore_case_q <= 1'b0;
			count_only_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_PATTERN_LOW:  pat_low_q     <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q    <= cfg_data;
				REG_PATTERN_LEN:  plen_q        <= cfg_data[PLEN_W-1:0];
				REG_IGNORE_CASE:  ignore_case_q <= cfg_data[0];
				REG_COUNT_ONLY:   count_only_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern        = {pat_high_q, pat_low_q};
	assign cfg.pattern_length = plen_q;
	assign cfg.ignore_case    = ignore_case_q;
	assign cfg.count_only     = count_only_q;

endmodule

FILE: sv/lsf_line_engine.sv
// line state, byte window, pattern compare and counters
module lsf_line_engine
	import lsf_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
	parameter int LINE_BUFFER = LINE_BUFFER_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  item_t    item,
	input  logic     step,
	output eng_res_t res
);

	localparam int PAT_N = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
	localparam int LP_W  = $clog2(LINE_BUFFER);
	localparam int LPC_W = ((LP_W > PLEN_W) ? LP_W : PLEN_W) + 1;
	localparam logic [LP_W-1:0] LINE_LAST = LP_W'(LINE_BUFFER - 1);

	logic [7:0]         win_q [MAX_PATTERN];
	logic [7:0]         win_next [MAX_PATTERN];
	logic [LP_W-1:0]    lp_q;
	logic               zero_q;
	logic               has_q;
	logic [COUNT_W-1:0] lines_q;
	logic [COUNT_W-1:0] matches_q;

	logic [7:0]         patf [PAT_N];
	logic [PLEN_W-1:0]  eff_len;
	logic [7:0]         cf;
	logic               is_end;
	logic               is_nl;
	logic               searching;
	logic               long_enough;
	logic               len_hit;
	logic               hit_now;
	logic [LP_W-1:0]    lp_inc;
	logic               close_line;
	logic               matched;
	logic               report;
	logic [COUNT_W-1:0] lines_c;
	logic [COUNT_W-1:0] matches_c;
	result_t            rep_rec;
	result_t            sum_rec;

	// pattern length in use, clamped to what is stored and compared
	assign eff_len = (cfg.pattern_length > PLEN_W'(PAT_N)) ? PLEN_W'(PAT_N)
	                                                      : cfg.pattern_length;

	// folded pattern characters
	always_comb begin
		for (int i = 0; i < PAT_N; i++) begin
			patf[i] = fold_case(cfg.pattern[8*i +: 8], cfg.ignore_case);
		end
	end

	// classify the byte
	assign cf        = fold_case(item.data_byte, cfg.ignore_case);
	assign is_end    = (item.req_type == REQ_END);
	assign is_nl     = (item.data_byte == NEWLINE);
	assign searching = !is_end && !is_nl && !zero_q && (item.data_byte != NUL_BYTE);

	// window with the new byte shifted in at the newest end
	always_comb begin
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_next[i] = win_q[i+1];
		end
		win_next[MAX_PATTERN-1] = cf;
	end

	// compare the newest bytes against the pattern, one term per length
	always_comb begin
		logic all_eq;
		len_hit = 1'b0;
		for (int l = 1; l <= PAT_N; l++) begin
			all_eq = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (win_next[MAX_PATTERN-l+i] != patf[i]) begin
					all_eq = 1'b0;
				end
			end
			if (eff_len == PLEN_W'(l)) begin
				len_hit = all_eq;
			end
		end
	end

	// enough bytes of this line in the window for the pattern
	assign long_enough = (LPC_W'(lp_q) + LPC_W'(1)) >= LPC_W'(eff_len);
	assign hit_now     = searching && (eff_len != '0) && long_enough && len_hit;

	// line end by newline, by length or by end of input
	assign lp_inc     = lp_q + LP_W'(1);
	assign close_line = (!is_end && is_nl)
	                 || (!is_end && !is_nl && lp_inc >= LINE_LAST)
	                 || (is_end && lp_q != '0);
	assign matched    = (eff_len == '0) || has_q || hit_now;
	assign report     = close_line && matched && !cfg.count_only;
	assign lines_c    = close_line ? sat_inc(lines_q) : lines_q;
	assign matches_c  = (close_line && matched) ? sat_inc(matches_q) : matches_q;

	// result records
	always_comb begin
		rep_rec.result_kind = KIND_REPORT;
		rep_rec.line_number = lines_c;
		rep_rec.match_count = matches_c;
		rep_rec.any_match   = (matches_c != '0);
		rep_rec.last        = !is_end;

		sum_rec.result_kind = KIND_SUMMARY;
		sum_rec.line_number = lines_c;
		sum_rec.match_count = matches_c;
		sum_rec.any_match   = (matches_c != '0);
		sum_rec.last        = 1'b1;

		res.count  = {1'b0, report} + {1'b0, is_end};
		res.first  = report ? rep_rec : sum_rec;
		res.second = sum_rec;
	end

	// line and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q      <= '0;
			zero_q    <= 1'b0;
			has_q     <= 1'b0;
			lines_q   <= '0;
			matches_q <= '0;
		end else if (step) begin
			if (is_end) begin
				lp_q      <= '0;
				zero_q    <= 1'b0;
				has_q     <= 1'b0;
				lines_q   <= '0;
				matches_q <= '0;
			end else if (close_line) begin
				lp_q      <= '0;
				zero_q    <= 1'b0;
				has_q     <= 1'b0;
				lines_q   <= lines_c;
				matches_q <= matches_c;
			end else begin
				lp_q   <= lp_inc;
				zero_q <= zero_q || (item.data_byte == NUL_BYTE);
				has_q  <= has_q || hit_now;
			end
		end
	end

	// window bytes, stale ones from an earlier line are never compared
	always_ff @(posedge clk) begin
		if (step && searching) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

endmodule

FILE: sv/lsf_out_queue.sv
// two-entry result queue, takes up to two results in one cycle
module lsf_out_queue
	import lsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  eng_res_t res,
	output logic [1:0] room,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] count_q;
	logic [1:0] rem;
	logic [1:0] added;
	logic       pop;
	result_t    keep;

	assign pop          = result_valid && !result_stall;
	assign rem          = count_q - {1'b0, pop};
	assign room         = 2'd2 - rem;
	assign added        = push ? res.count : 2'd0;
	assign keep         = pop ? tail_q : head_q;
	assign result_valid = (count_q != 2'd0);
	assign result       = head_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= rem + added;
		end
	end

	// entries, new results go behind whatever remains
	always_ff @(posedge clk) begin
		unique case (rem)
			2'd0: begin
				head_q <= res.first;
				tail_q <= res.second;
			end
			2'd1: begin
				head_q <= keep;
				tail_q <= res.first;
			end
			default: begin
				head_q <= head_q;
				tail_q <= tail_q;
			end
		endcase
	end

endmodule

FILE: sv/line_substring_filter.sv
// top level of the line substring filter
//
//  channel   direction  handshake                 beat
//  item      in         item_valid / item_stall   item_t: req_type, data_byte
//  result    out        result_valid / result_stall  result_t: kind, line, count, flags
//  cfg       in         cfg_we                    cfg_index, cfg_data (64 bits)
//
// one item is taken per cycle unless stalled; results are registered in the result queue.
// the input register feeds a single pass of compare logic into a two-entry
// result queue; an end of input that closes a matching line gives two results,
// which the queue takes together, so a free result side never stalls the input.
// a stalled result side fills the queue and then stalls the input.
// reset clears all line state, counters and configuration registers.
module line_substring_filter
	import lsf_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
	parameter int LINE_BUFFER = LINE_BUFFER_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	eng_res_t   res;
	logic [1:0] room;
	logic       step;

	lsf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	assign step       = valid_s1 && (res.count <= room);
	assign item_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	lsf_line_engine #(
		.MAX_PATTERN (MAX_PATTERN),
		.LINE_BUFFER (LINE_BUFFER)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (step),
		.res    (res)
	);

	lsf_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (step),
		.res          (res),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// two results from one item are a report followed by the summary
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.count == 2'd2
		|-> !res.first.last && res.first.result_kind == KIND_REPORT
		    && res.second.result_kind == KIND_SUMMARY)
		else $error("two results not a report then a summary");

	// a non-final report is always followed directly by the summary
	a_summary_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.result_kind == KIND_REPORT
		&& !result.last
		|=> result_valid && result.result_kind == KIND_SUMMARY)
		else $error("summary missing after end of input report");

	// end of input always yields a summary
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.req_type == REQ_END |-> res.count != 2'd0)
		else $error("end of input without summary");

	// the input only stalls on an item held in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res.count > room)
		else $error("input stalled without a blocked item");

endmodule

FILE: sim/tb_line_substring_filter.sv
// line substring filter testbench: directed rows, a long line, random text, checked beat by beat
`timescale 1ns / 100ps

module tb_line_substring_filter;
	import lsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RANDOM_BEATS   = 950;

	// one row of the directed stimulus, either a register write or an item beat
	typedef struct packed {
		logic       cfg_row;
		cfg_reg_e   reg_idx;
		logic [CFG_W-1:0] reg_val;
		item_t      beat;
		logic       typed;
		logic [1:0] typed_n;
		result_t    typed_a;
		result_t    typed_b;
	} stim_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	// predictor copy of the configuration
	logic [CFG_W-1:0] pat_lo   = '0;
	logic [CFG_W-1:0] pat_hi   = '0;
	int               pat_len  = 0;
	bit               fold_on  = 1'b0;
	bit               cnt_only = 1'b0;

	// predictor copy of the line state
	logic [7:0]         window_bytes [MAX_PATTERN_DEFAULT];
	int                 line_pos   = 0;
	bit                 nul_seen   = 1'b0;
	bit                 line_hit   = 1'b0;
	logic [COUNT_W-1:0] lines_read = '0;
	logic [COUNT_W-1:0] hits       = '0;

	// results of the latest beat, and results still owed by the block
	result_t fresh [2];
	int      fresh_n;
	result_t due_results [$];
	result_t head_result;

	// stimulus bookkeeping
	logic [7:0] phase_pat [PAT_STORE];
	int         phase_eff   = 0;
	logic [7:0] line_q [$];
	stim_row_t  dir_rows [$];
	bit         quiet       = 1'b0;
	int         beats_sent  = 0;
	int         fail_count  = 0;
	int         stall_left  = 0;
	int         idle_cycles = 0;
	int         row_i;
	int         random_start;
	int         phase_no;
	int         k_main;

	line_substring_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic result_t res(logic kind, logic [COUNT_W-1:0] ln,
			logic [COUNT_W-1:0] mc, logic any, logic fin);
		result_t r;
		r.result_kind = kind;
		r.line_number = ln;
		r.match_count = mc;
		r.any_match   = any;
		r.last        = fin;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = int'($urandom_range(0, 99));
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return int'($urandom_range(1, 3));
		end
		if (r < 97) begin
			return int'($urandom_range(4, 12));
		end
		return int'($urandom_range(20, 60));
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a);
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		if (fold_on && c >= UPPER_A && c <= UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic int eff_len();
		return (pat_len > PAT_STORE) ? PAT_STORE : pat_len;
	endfunction

	function automatic logic [7:0] pat_char(int k);
		if (k < 8) begin
			return lower(pat_lo[8*k +: 8]);
		end
		return lower(pat_hi[8*(k-8) +: 8]);
	endfunction

	function automatic void clear_line();
		for (int k = 0; k < MAX_PATTERN_DEFAULT; k++) begin
			window_bytes[k] = 8'h00;
		end
		line_pos = 0;
		nul_seen = 1'b0;
		line_hit = 1'b0;
	endfunction

	// close the open line, report it when it matched
	function automatic void close_line(logic fin);
		if (lines_read != '1) begin
			lines_read = lines_read + 32'd1;
		end
		if (eff_len() == 0 || line_hit) begin
			if (hits != '1) begin
				hits = hits + 32'd1;
			end
			if (!cnt_only) begin
				fresh[fresh_n] = res(KIND_REPORT, lines_read, hits, hits != '0, fin);
				fresh_n++;
			end
		end
		clear_line();
	endfunction

	// shift a searched byte into the window and compare the pattern tail
	function automatic void slide_in(logic [7:0] c);
		int  plen;
		bit  hit;
		plen = eff_len();
		hit  = 1'b1;
		for (int k = 0; k < MAX_PATTERN_DEFAULT - 1; k++) begin
			window_bytes[k] = window_bytes[k+1];
		end
		window_bytes[MAX_PATTERN_DEFAULT-1] = lower(c);
		if (plen == 0 || line_pos + 1 < plen) begin
			return;
		end
		for (int k = 0; k < plen; k++) begin
			if (window_bytes[MAX_PATTERN_DEFAULT - plen + k] != pat_char(k)) begin
				hit = 1'b0;
			end
		end
		if (hit) begin
			line_hit = 1'b1;
		end
	endfunction

	// results caused by one accepted beat, left in fresh
	function automatic void advance_filter(item_t b);
		fresh_n = 0;
		if (b.req_type == REQ_END) begin
			if (line_pos > 0) begin
				close_line(1'b0);
			end
			fresh[fresh_n] = res(KIND_SUMMARY, lines_read, hits, hits != '0, 1'b1);
			fresh_n++;
			clear_line();
			lines_read = '0;
			hits       = '0;
		end else if (b.data_byte == NEWLINE) begin
			close_line(1'b1);
		end else begin
			if (!nul_seen) begin
				if (b.data_byte == NUL_BYTE) begin
					nul_seen = 1'b1;
				end else begin
					slide_in(b.data_byte);
				end
			end
			line_pos++;
			if (line_pos >= LINE_BUFFER_DEFAULT - 1) begin
				close_line(1'b1);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// offer one item beat after a random gap and wait for it to be taken
	task automatic push_beat(logic rt, logic [7:0] c, bit take_prediction);
		int    gap;
		item_t b;
		b.req_type  = rt;
		b.data_byte = c;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		beats_sent++;
		advance_filter(b);
		if (take_prediction) begin
			for (int k = 0; k < fresh_n; k++) begin
				due_results.push_back(fresh[k]);
			end
		end
	endtask

	// register write once the block has gone quiet
	task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
		item_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_PATTERN_LOW:  pat_lo   = v;
			REG_PATTERN_HIGH: pat_hi   = v;
			REG_PATTERN_LEN:  pat_len  = int'(v[PLEN_W-1:0]);
			REG_IGNORE_CASE:  fold_on  = v[0];
			REG_COUNT_ONLY:   cnt_only = v[0];
			default: ;
		endcase
	endtask

	task automatic flush_line();
		foreach (line_q[i]) begin
			push_beat(REQ_BYTE, line_q[i], 1'b1);
		end
		line_q.delete();
	endtask

	// text byte that often repeats a pattern character
	function automatic logic [7:0] filler_byte();
		logic [7:0] c;
		if (phase_eff > 0 && $urandom_range(0, 1) == 1) begin
			c = phase_pat[$urandom_range(0, phase_eff - 1)];
		end else begin
			c = 8'h61 + 8'($urandom_range(0, 5));
		end
		if (c == NEWLINE || c == NUL_BYTE) begin
			c = 8'h2e;
		end
		if (is_letter(c) && $urandom_range(0, 3) == 0) begin
			c = c ^ CASE_OFFSET;
		end
		return c;
	endfunction

	// pattern copy with case flips, one character spoilt when spoil is in range
	task automatic append_pattern(int spoil);
		logic [7:0] c;
		for (int k = 0; k < phase_eff; k++) begin
			c = phase_pat[k];
			if (is_letter(c)) begin
				if (fold_on ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 19) == 0)) begin
					c = c ^ CASE_OFFSET;
				end
			end
			if (k == spoil) begin
				c = c + 8'd1;
			end
			line_q.push_back(c);
		end
	endtask

	// one line of random shape, mostly well formed
	task automatic send_random_line();
		int r;
		r = int'($urandom_range(0, 99));
		repeat ($urandom_range(0, 8)) line_q.push_back(filler_byte());
		if (r < 50) begin
			append_pattern(-1);
		end else if (r < 62) begin
			append_pattern((phase_eff > 0) ? int'($urandom_range(0, phase_eff - 1)) : -1);
		end else if (r < 72) begin
			if ($urandom_range(0, 1) == 1) begin
				line_q.push_back(NUL_BYTE);
				append_pattern(-1);
			end else begin
				append_pattern(-1);
				line_q.push_back(NUL_BYTE);
			end
		end else if (r < 84) begin
			repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
		end else if (r < 92) begin
			line_q.delete();
		end else begin
			// partial line closed by end of input
			append_pattern(-1);
			flush_line();
			push_beat(REQ_END, 8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		repeat ($urandom_range(0, 8)) line_q.push_back(filler_byte());
		line_q.push_back(NEWLINE);
		flush_line();
	endtask

	// one setting of the registers, then random text and an end of input
	task automatic run_phase(int idx);
		int               plen;
		logic             ic;
		logic             co;
		int               r;
		int               stop_at;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [CFG_W-1:0] noise;
		quiet = (idx % 5 == 3);
		for (int k = 0; k < PAT_STORE; k++) begin
			case ($urandom_range(0, 2))
				0: phase_pat[k] = 8'h41 + 8'($urandom_range(0, 3));
				1: phase_pat[k] = 8'h61 + 8'($urandom_range(0, 3));
				default: phase_pat[k] = 8'h30 + 8'($urandom_range(0, 2));
			endcase
		end
		r = int'($urandom_range(0, 9));
		if (r == 0) begin
			plen = 0;
		end else if (r == 1) begin
			plen = int'($urandom_range(17, 31));
		end else begin
			plen = int'($urandom_range(1, 16));
		end
		ic = 1'($urandom_range(0, 1));
		co = ($urandom_range(0, 3) == 0);
		r  = int'($urandom_range(0, 9));
		if (r == 0) begin
			phase_pat[$urandom_range(0, PAT_STORE - 1)] = NUL_BYTE;
		end else if (r == 1) begin
			for (int k = 0; k < PAT_STORE; k++) begin
				phase_pat[k] = 8'($urandom_range(0, 255));
			end
		end
		// extreme settings first
		case (idx)
			0: begin
				for (int k = 0; k < PAT_STORE; k++) begin
					phase_pat[k] = 8'hff;
				end
				plen = 16;
				ic   = 1'b1;
				co   = 1'b0;
			end
			1: begin
				plen = 31;
				co   = 1'b0;
			end
			2: begin
				plen = 0;
				co   = 1'b1;
			end
			3: begin
				plen = 1;
				ic   = 1'b1;
				co   = 1'b0;
			end
			4: begin
				plen = 5;
				phase_pat[2] = NUL_BYTE;
			end
			default: ;
		endcase
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = phase_pat[k];
			hi[8*k +: 8] = phase_pat[k+8];
		end
		noise = {$urandom, $urandom};
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LEN, {noise[CFG_W-1:PLEN_W], 5'(plen)});
		noise = {$urandom, $urandom};
		write_reg(REG_IGNORE_CASE, {noise[CFG_W-1:1], ic});
		noise = {$urandom, $urandom};
		write_reg(REG_COUNT_ONLY, {noise[CFG_W-1:1], co});
		phase_eff = eff_len();
		stop_at = beats_sent + int'($urandom_range(40, 90));
		while (beats_sent < stop_at) begin
			send_random_line();
		end
		push_beat(REQ_END, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic stim_row_t beat_row(logic rt, logic [7:0] c);
		stim_row_t row;
		row = '0;
		row.beat.req_type  = rt;
		row.beat.data_byte = c;
		return row;
	endfunction

	function automatic stim_row_t seen_row(logic rt, logic [7:0] c, logic [1:0] n,
			result_t a, result_t b);
		stim_row_t row;
		row = beat_row(rt, c);
		row.typed   = 1'b1;
		row.typed_n = n;
		row.typed_a = a;
		row.typed_b = b;
		return row;
	endfunction

	function automatic stim_row_t reg_row(cfg_reg_e r, logic [CFG_W-1:0] v);
		stim_row_t row;
		row = '0;
		row.cfg_row = 1'b1;
		row.reg_idx = r;
		row.reg_val = v;
		return row;
	endfunction

	// result side: random stall and beat-by-beat compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				result_stall <= !quiet && ($urandom_range(0, 2) == 0);
				stall_left   <= pick_gap();
			end
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("result beat with nothing expected: kind %0d line %0d",
						result.result_kind, result.line_number);
					fail_count++;
				end else begin
					head_result = due_results.pop_front();
					check_field("result_kind", 32'(head_result.result_kind),
						32'(result.result_kind));
					check_field("line_number", head_result.line_number, result.line_number);
					check_field("match_count", head_result.match_count, result.match_count);
					check_field("any_match", 32'(head_result.any_match), 32'(result.any_match));
					check_field("last", 32'(head_result.last), 32'(result.last));
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[line_substring_filter] ERROR");
			$finish;
		end
	end

	initial begin
		clear_line();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty pattern, so every line matches
		dir_rows.push_back(seen_row(REQ_BYTE, 8'h61, 2'd0, '0, '0));
		dir_rows.push_back(seen_row(REQ_BYTE, NEWLINE, 2'd1,
			res(KIND_REPORT, 32'd1, 32'd1, 1'b1, 1'b1), '0));
		dir_rows.push_back(seen_row(REQ_BYTE, NEWLINE, 2'd1,
			res(KIND_REPORT, 32'd2, 32'd2, 1'b1, 1'b1), '0));
		dir_rows.push_back(seen_row(REQ_BYTE, 8'hff, 2'd0, '0, '0));
		dir_rows.push_back(seen_row(REQ_BYTE, NUL_BYTE, 2'd0, '0, '0));
		dir_rows.push_back(seen_row(REQ_END, 8'hff, 2'd2,
			res(KIND_REPORT, 32'd3, 32'd3, 1'b1, 1'b0),
			res(KIND_SUMMARY, 32'd3, 32'd3, 1'b1, 1'b1)));
		// end of input with no partial line, fresh stream
		dir_rows.push_back(seen_row(REQ_END, 8'h00, 2'd1,
			res(KIND_SUMMARY, 32'd0, 32'd0, 1'b0, 1'b1), '0));
		// pattern aBc with case folding
		dir_rows.push_back(reg_row(REG_PATTERN_LOW, 64'h0000_0000_0063_4261));
		dir_rows.push_back(reg_row(REG_PATTERN_HIGH, 64'hffff_ffff_ffff_ffff));
		dir_rows.push_back(reg_row(REG_PATTERN_LEN, 64'd3));
		dir_rows.push_back(reg_row(REG_IGNORE_CASE, 64'd1));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h41));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h62));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h43));
		dir_rows.push_back(beat_row(REQ_BYTE, NEWLINE));
		// zero byte hides the rest of the line
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h61));
		dir_rows.push_back(beat_row(REQ_BYTE, NUL_BYTE));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h62));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h63));
		dir_rows.push_back(beat_row(REQ_BYTE, NEWLINE));
		// matching partial line flushed by end of input
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h61));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h62));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h63));
		dir_rows.push_back(beat_row(REQ_END, 8'h55));
		// count only: summary alone
		dir_rows.push_back(reg_row(REG_COUNT_ONLY, 64'd1));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h41));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h42));
		dir_rows.push_back(beat_row(REQ_BYTE, 8'h43));
		dir_rows.push_back(beat_row(REQ_BYTE, NEWLINE));
		dir_rows.push_back(beat_row(REQ_END, 8'haa));

		for (row_i = 0; row_i < dir_rows.size(); row_i++) begin
			if (dir_rows[row_i].cfg_row) begin
				write_reg(dir_rows[row_i].reg_idx, dir_rows[row_i].reg_val);
			end else begin
				push_beat(dir_rows[row_i].beat.req_type, dir_rows[row_i].beat.data_byte,
					!dir_rows[row_i].typed);
				if (dir_rows[row_i].typed && dir_rows[row_i].typed_n > 2'd0) begin
					due_results.push_back(dir_rows[row_i].typed_a);
				end
				if (dir_rows[row_i].typed && dir_rows[row_i].typed_n > 2'd1) begin
					due_results.push_back(dir_rows[row_i].typed_b);
				end
			end
		end

		// long line cut at the buffer limit, pattern in its last bytes
		write_reg(REG_PATTERN_LOW, 64'h0000_0000_007a_7978);
		write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
		write_reg(REG_PATTERN_LEN, 64'd3);
		write_reg(REG_IGNORE_CASE, 64'd0);
		write_reg(REG_COUNT_ONLY, 64'd0);
		for (k_main = 0; k_main < LINE_BUFFER_DEFAULT - 4; k_main++) begin
			line_q.push_back(8'h61 + 8'($urandom_range(0, 22)));
		end
		line_q.push_back(8'h78);
		line_q.push_back(8'h79);
		line_q.push_back(8'h7a);
		line_q.push_back(NEWLINE);
		flush_line();
		push_beat(REQ_END, 8'($urandom_range(0, 255)), 1'b1);

		// random phases
		random_start = beats_sent;
		phase_no     = 0;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			run_phase(phase_no);
			phase_no++;
		end

		item_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES + 2) @(posedge clk);
		if (fail_count == 0) begin
			$display("[line_substring_filter] OK");
		end else begin
			$display("[line_substring_filter] ERROR");
		end
		$finish;
	end

endmodule
